/* rtl/mbsa_pkg.sv */
package mbsa_pkg;

  // Sizes of the storage areas and of the occupancy bitmap.
  localparam int unsigned Areas        = 4;
  localparam int unsigned PagesPerArea = 1024;
  localparam int unsigned WordBits     = 32;
  localparam int unsigned WordsPerArea = (PagesPerArea + WordBits - 1) / WordBits;
  localparam int unsigned AreaAw       = $clog2(Areas);
  localparam int unsigned WordAw       = $clog2(WordsPerArea);
  localparam int unsigned BitAw        = $clog2(WordBits);
  localparam int unsigned MapDepth     = Areas * WordsPerArea;
  localparam int unsigned MapAw        = $clog2(MapDepth);

  // Field widths.
  localparam int unsigned CountW    = 11;
  localparam int unsigned AreaCntW  = 3;
  localparam int unsigned EntryW    = 32;
  localparam int unsigned AreaShift = 24;
  localparam int unsigned CfgIdxW   = 3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgAreaCount = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgArea0Pages = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgArea3Pages = 3'd4;

  typedef enum logic {
    OpAlloc = 1'b0,
    OpFree  = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StInvalid = 2'd1,
    StNoSpace = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    SIdle,
    SAllocArea,
    SAllocRead,
    SAllocCheck,
    SFreeRead,
    SFreeCheck,
    SFinish
  } state_e;

endpackage

/* rtl/mbsa_ram.sv */
module mbsa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/multi_area_bitmap_slot_allocator.sv */
// First-fit slot allocator over up to four storage areas.
// Requests arrive on the s_axis channel: tuser carries the opcode (allocate
// or free) and tdata the 32-bit slot entry to free (area in bits 31..24,
// page in bits 23..0), which is ignored on allocate. Every request produces
// exactly one item on the m_axis channel: tuser holds the status (ok,
// invalid entry, no free slot) and tdata the granted entry, zero unless an
// allocate succeeded. Area count and page counts are written through the cfg
// port only while the block is idle; the user must keep to this, as the
// block does not enforce it. The block works on one request at a time; an
// allocate walks the areas in order, skipping those its used counter shows
// full, and reads one bitmap word at a time, then checks it, through the
// single registered read port of the bitmap RAM. A free reads the entry's
// word and checks it unless the entry is outside configured areas and pages.
// Reset clears the control and configuration registers, the used counters
// and one valid flag per bitmap word; a word never written reads as all pages
// free, so no clearing pass is needed; the block is ready right after reset.
// A result waits in the output register while the receiver stalls; the next
// request is still taken, and its result is held until the output frees up.
module multi_area_bitmap_slot_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [10:0] cfg_wdata_i,
  // Request channel.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // slot_entry[31:0]
  input  logic        s_axis_tuser,   // opcode[0]
  // Result channel.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // granted_entry[31:0]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  localparam int unsigned CountW = mbsa_pkg::CountW;
  localparam int unsigned WordAw = mbsa_pkg::WordAw;
  localparam int unsigned BitAw  = mbsa_pkg::BitAw;
  localparam int unsigned MapAw  = mbsa_pkg::MapAw;
  localparam int unsigned AreaAw = mbsa_pkg::AreaAw;
  localparam int unsigned WordW  = mbsa_pkg::WordBits;

  // Configuration registers.
  logic [mbsa_pkg::AreaCntW-1:0] area_count_q;
  logic [CountW-1:0]             pages_q [mbsa_pkg::Areas];

  // Sequencer state.
  mbsa_pkg::state_e              state_q, state_d;
  logic                          op_q, op_d;
  logic [mbsa_pkg::EntryW-1:0]   entry_q, entry_d;
  logic [mbsa_pkg::AreaCntW-1:0] area_q, area_d;
  logic [WordAw-1:0]             word_q, word_d;
  logic [CountW-1:0]             used_q [mbsa_pkg::Areas];
  logic [CountW-1:0]             used_d [mbsa_pkg::Areas];
  mbsa_pkg::status_e             res_status_q, res_status_d;
  logic [mbsa_pkg::EntryW-1:0]   res_entry_q, res_entry_d;

  // Output register.
  logic                          m_valid_q, m_valid_d;
  mbsa_pkg::status_e             m_status_q, m_status_d;
  logic [mbsa_pkg::EntryW-1:0]   m_entry_q, m_entry_d;

  // Bitmap RAM and its per-word valid flags.
  logic                          ram_we;
  logic [MapAw-1:0]              ram_waddr, ram_raddr;
  logic [WordW-1:0]              ram_wdata, ram_rdata;
  logic [mbsa_pkg::MapDepth-1:0] word_valid_q;
  logic                          rd_valid_q;

  // Derived values for the area being inspected.
  logic [mbsa_pkg::AreaCntW-1:0] live_areas;
  logic [AreaAw-1:0]             cur_area;
  logic [CountW-1:0]             cur_size;
  logic [WordAw-1:0]             last_word;
  logic [WordW-1:0]              map_word;
  logic [WordW-1:0]              range_mask;
  logic [WordW-1:0]              free_bits;
  logic [BitAw-1:0]              first_free;
  logic [AreaAw-1:0]             fr_area;
  logic [CountW-1:0]             fr_size;
  logic                          fr_in_range;
  logic [BitAw-1:0]              fr_bit;

  function automatic logic [CountW-1:0] clamp_pages(input logic [CountW-1:0] p);
    logic [CountW-1:0] lim;
    lim = CountW'(mbsa_pkg::PagesPerArea);
    return (p > lim) ? lim : p;
  endfunction

  function automatic logic [BitAw-1:0] lowest_set(input logic [WordW-1:0] v);
    logic [BitAw-1:0] idx;
    idx = '0;
    for (int i = WordW - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = BitAw'(i);
      end
    end
    return idx;
  endfunction

  assign live_areas = (area_count_q > mbsa_pkg::AreaCntW'(mbsa_pkg::Areas))
                      ? mbsa_pkg::AreaCntW'(mbsa_pkg::Areas) : area_count_q;

  assign cur_area  = area_q[AreaAw-1:0];
  assign cur_size  = clamp_pages(pages_q[cur_area]);
  assign last_word = WordAw'((cur_size - CountW'(1)) >> BitAw);

  // A word never written since reset holds only free pages.
  assign map_word = rd_valid_q ? ram_rdata : '0;

  // Pages of the current word that lie inside the area; page zero of area
  // zero is reserved and never offered.
  always_comb begin
    if ({1'b0, word_q} < (CountW - BitAw)'(cur_size >> BitAw)) begin
      range_mask = '1;
    end else begin
      range_mask = (WordW'(1) << cur_size[BitAw-1:0]) - WordW'(1);
    end
    if (cur_area == '0 && word_q == '0) begin
      range_mask[0] = 1'b0;
    end
  end

  assign free_bits  = ~map_word & range_mask;
  assign first_free = lowest_set(free_bits);

  // Free request decoding.
  assign fr_area     = entry_q[mbsa_pkg::AreaShift +: AreaAw];
  assign fr_size     = clamp_pages(pages_q[fr_area]);
  assign fr_bit      = entry_q[BitAw-1:0];
  assign fr_in_range = (entry_q != '0)
                       && (entry_q[31:24] < 8'(live_areas))
                       && (entry_q[23:0] < 24'(fr_size));

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    entry_d      = entry_q;
    area_d       = area_q;
    word_d       = word_q;
    used_d       = used_q;
    res_status_d = res_status_q;
    res_entry_d  = res_entry_q;
    m_valid_d    = m_valid_q;
    m_status_d   = m_status_q;
    m_entry_d    = m_entry_q;
    ram_we       = 1'b0;
    ram_waddr    = {cur_area, word_q};
    ram_wdata    = map_word;
    ram_raddr    = {cur_area, word_q};
    s_axis_tready = 1'b0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      mbsa_pkg::SIdle: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          op_d    = s_axis_tuser;
          entry_d = s_axis_tdata;
          area_d  = '0;
          word_d  = '0;
          state_d = (s_axis_tuser == mbsa_pkg::OpFree) ? mbsa_pkg::SFreeRead
                                                        : mbsa_pkg::SAllocArea;
        end
      end

      mbsa_pkg::SAllocArea: begin
        if (area_q >= live_areas) begin
          res_status_d = mbsa_pkg::StNoSpace;
          res_entry_d  = '0;
          state_d      = mbsa_pkg::SFinish;
        end else if (used_q[cur_area] >= cur_size) begin
          area_d = area_q + 1'b1;
        end else begin
          word_d  = '0;
          state_d = mbsa_pkg::SAllocRead;
        end
      end

      mbsa_pkg::SAllocRead: begin
        state_d = mbsa_pkg::SAllocCheck;
      end

      mbsa_pkg::SAllocCheck: begin
        if (free_bits != '0) begin
          ram_we             = 1'b1;
          ram_wdata          = map_word | (WordW'(1) << first_free);
          used_d[cur_area]   = used_q[cur_area] + 1'b1;
          res_status_d       = mbsa_pkg::StOk;
          res_entry_d        = {6'b0, cur_area, 14'b0, word_q, first_free};
          state_d            = mbsa_pkg::SFinish;
        end else if (word_q == last_word) begin
          // Counter says there is room but the range has none left.
          area_d  = area_q + 1'b1;
          state_d = mbsa_pkg::SAllocArea;
        end else begin
          word_d  = word_q + 1'b1;
          state_d = mbsa_pkg::SAllocRead;
        end
      end

      mbsa_pkg::SFreeRead: begin
        ram_raddr = {fr_area, entry_q[BitAw +: WordAw]};
        if (fr_in_range) begin
          state_d = mbsa_pkg::SFreeCheck;
        end else begin
          res_status_d = mbsa_pkg::StInvalid;
          res_entry_d  = '0;
          state_d      = mbsa_pkg::SFinish;
        end
      end

      mbsa_pkg::SFreeCheck: begin
        ram_waddr    = {fr_area, entry_q[BitAw +: WordAw]};
        res_entry_d  = '0;
        res_status_d = mbsa_pkg::StInvalid;
        if (map_word[fr_bit]) begin
          ram_we       = 1'b1;
          ram_wdata    = map_word & ~(WordW'(1) << fr_bit);
          res_status_d = mbsa_pkg::StOk;
          if (used_q[fr_area] != '0) begin
            used_d[fr_area] = used_q[fr_area] - 1'b1;
          end
        end
        state_d = mbsa_pkg::SFinish;
      end

      mbsa_pkg::SFinish: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d  = 1'b1;
          m_status_d = res_status_q;
          m_entry_d  = res_entry_q;
          state_d    = mbsa_pkg::SIdle;
        end
      end

      default: begin
        state_d = mbsa_pkg::SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mbsa_pkg::SIdle;
      area_count_q <= '0;
      m_valid_q    <= 1'b0;
      word_valid_q <= '0;
      rd_valid_q   <= 1'b0;
      for (int i = 0; i < mbsa_pkg::Areas; i++) begin
        pages_q[i] <= '0;
        used_q[i]  <= '0;
      end
    end else begin
      state_q    <= state_d;
      m_valid_q  <= m_valid_d;
      used_q     <= used_d;
      rd_valid_q <= word_valid_q[ram_raddr];
      if (ram_we) begin
        word_valid_q[ram_waddr] <= 1'b1;
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == mbsa_pkg::CfgAreaCount) begin
          area_count_q <= cfg_wdata_i[mbsa_pkg::AreaCntW-1:0];
        end else if (cfg_idx_i >= mbsa_pkg::CfgArea0Pages
                     && cfg_idx_i <= mbsa_pkg::CfgArea3Pages) begin
          pages_q[AreaAw'(cfg_idx_i - mbsa_pkg::CfgArea0Pages)] <= cfg_wdata_i;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    entry_q      <= entry_d;
    area_q       <= area_d;
    word_q       <= word_d;
    res_status_q <= res_status_d;
    res_entry_q  <= res_entry_d;
    m_status_q   <= m_status_d;
    m_entry_q    <= m_entry_d;
  end

  mbsa_ram #(
    .Width (WordW),
    .Depth (mbsa_pkg::MapDepth)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_entry_q;
  assign m_axis_tuser  = m_status_q;

endmodule
